@@ src/xld_pkg.sv @@
// Shared types, constants and the opcode table of the x86 instruction length decoder.
`default_nettype none

package xld_pkg;

  // Legacy prefix limit and the width of the prefix counter that follows from it.
  localparam int unsigned MAX_PREFIXES = 4;
  localparam int unsigned PcW = $clog2(MAX_PREFIXES + 1);

  // Special byte values.
  localparam logic [7:0] OPSIZE_PREFIX = 8'h66;
  localparam logic [3:0] REX_HIGH      = 4'h4;

  // Configuration register indexes and reset value.
  localparam logic       REG_MIN_LENGTH   = 1'b0;
  localparam logic [6:0] MIN_LENGTH_RESET = 7'd5;

  // Decoder phases.
  typedef enum logic [2:0] {
    PH_PREFIX   = 3'd0,
    PH_OPCODE   = 3'd1,
    PH_MODRM    = 3'd2,
    PH_SIB_MOD0 = 3'd3,
    PH_SIB      = 3'd4,
    PH_TAIL     = 3'd5
  } phase_e;

  // Opcode attribute flags.
  typedef struct packed {
    logic rel;
    logic i32;
    logic i16;
    logic i8;
    logic group;
    logic modrm;
  } op_flags_t;

  localparam logic [5:0] F_MODRM = 6'b000001;
  localparam logic [5:0] F_GROUP = 6'b000010;
  localparam logic [5:0] F_I8    = 6'b000100;
  localparam logic [5:0] F_I16   = 6'b001000;
  localparam logic [5:0] F_I32   = 6'b010000;
  localparam logic [5:0] F_REL   = 6'b100000;

  // Result of an opcode lookup.
  typedef struct packed {
    logic       found;
    op_flags_t  flags;
    logic [7:0] regs;
  } op_info_t;

  // One table entry: the opcode matches when (byte & care) == op.
  typedef struct packed {
    logic [7:0] op;
    logic [7:0] care;
    logic [5:0] flags;
    logic [7:0] regs;
  } op_entry_t;

  localparam int unsigned OP_COUNT = 47;

  localparam op_entry_t OP_TABLE [OP_COUNT] = '{
    '{8'h00, 8'hFC, F_MODRM, 8'h00}, '{8'h08, 8'hFC, F_MODRM, 8'h00},
    '{8'h20, 8'hFC, F_MODRM, 8'h00}, '{8'h28, 8'hFC, F_MODRM, 8'h00},
    '{8'h30, 8'hFC, F_MODRM, 8'h00}, '{8'h84, 8'hFE, F_MODRM, 8'h00},
    '{8'h88, 8'hFC, F_MODRM, 8'h00}, '{8'h8C, 8'hFF, F_MODRM, 8'h00},
    '{8'h8D, 8'hFF, F_MODRM, 8'h00}, '{8'h8E, 8'hFF, F_MODRM, 8'h00},
    '{8'h04, 8'hFF, F_I8, 8'h00}, '{8'h0C, 8'hFF, F_I8, 8'h00},
    '{8'h24, 8'hFF, F_I8, 8'h00}, '{8'h2C, 8'hFF, F_I8, 8'h00},
    '{8'h34, 8'hFF, F_I8, 8'h00}, '{8'hA8, 8'hFF, F_I8, 8'h00},
    '{8'h6A, 8'hFF, F_I8, 8'h00}, '{8'hA0, 8'hFF, F_I8, 8'h00},
    '{8'hA2, 8'hFF, F_I8, 8'h00},
    '{8'h05, 8'hFF, F_I32, 8'h00}, '{8'h0D, 8'hFF, F_I32, 8'h00},
    '{8'h25, 8'hFF, F_I32, 8'h00}, '{8'h2D, 8'hFF, F_I32, 8'h00},
    '{8'h35, 8'hFF, F_I32, 8'h00}, '{8'hA9, 8'hFF, F_I32, 8'h00},
    '{8'h68, 8'hFF, F_I32, 8'h00}, '{8'hA1, 8'hFF, F_I32, 8'h00},
    '{8'hA3, 8'hFF, F_I32, 8'h00},
    '{8'hE8, 8'hFE, F_I32 | F_REL, 8'h00},
    '{8'hC8, 8'hFF, F_I16 | F_I8, 8'h00}, '{8'hC2, 8'hFF, F_I16, 8'h00},
    '{8'hCC, 8'hFF, 6'b000000, 8'h00}, '{8'hC9, 8'hFF, 6'b000000, 8'h00},
    '{8'h90, 8'hFF, 6'b000000, 8'h00}, '{8'hC3, 8'hFF, 6'b000000, 8'h00},
    '{8'hB0, 8'hF8, F_I8, 8'h00}, '{8'hB8, 8'hF8, F_I32, 8'h00},
    '{8'h50, 8'hF0, 6'b000000, 8'h00},
    '{8'h80, 8'hFF, F_MODRM | F_GROUP | F_I8, 8'h73},
    '{8'h81, 8'hFF, F_MODRM | F_GROUP | F_I32, 8'h73},
    '{8'h83, 8'hFF, F_MODRM | F_GROUP | F_I8, 8'hF3},
    '{8'hFF, 8'hFF, F_MODRM | F_GROUP, 8'h56},
    '{8'hC6, 8'hFF, F_MODRM | F_GROUP | F_I8, 8'h01},
    '{8'hC7, 8'hFF, F_MODRM | F_GROUP | F_I32, 8'h01},
    '{8'h8F, 8'hFF, F_MODRM | F_GROUP, 8'h01},
    '{8'hF6, 8'hFF, F_MODRM | F_GROUP | F_I8, 8'h01},
    '{8'hF7, 8'hFF, F_MODRM | F_GROUP | F_I32, 8'h01}
  };

  // True for the eleven legacy prefix bytes.
  function automatic logic is_prefix(input logic [7:0] b);
    return (b == 8'hF0) || (b == 8'hF2) || (b == 8'hF3) || (b == 8'h2E) ||
           (b == 8'h36) || (b == 8'h3E) || (b == 8'h26) || (b == 8'h64) ||
           (b == 8'h65) || (b == 8'h66) || (b == 8'h67);
  endfunction

  // Immediate byte count; a 32-bit immediate takes the operand size.
  function automatic logic [3:0] imm_bytes(input op_flags_t f, input logic [3:0] opb);
    logic [3:0] n;
    n = 4'd0;
    if (f.i8)  n = n + 4'd1;
    if (f.i16) n = n + 4'd2;
    if (f.i32) n = n + opb;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ src/xld_op_decode.sv @@
// Opcode table lookup: first matching entry of the fixed opcode table.
`default_nettype none

module xld_op_decode (
  input  logic [7:0]        opcode_i,
  output xld_pkg::op_info_t info_o
);
  import xld_pkg::*;

  // Scan from the last entry down so that the first match wins.
  always_comb begin
    info_o = '0;
    for (int i = OP_COUNT - 1; i >= 0; i--) begin
      if ((opcode_i & OP_TABLE[i].care) == OP_TABLE[i].op) begin
        info_o.found = 1'b1;
        info_o.flags = op_flags_t'(OP_TABLE[i].flags);
        info_o.regs  = OP_TABLE[i].regs;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/x86_instruction_length_decoder_unit.sv @@
// Top level of the x86 instruction length decoder: byte stream in, one result per instruction.
//
// Code bytes arrive on the slave stream, one per transaction; tdata carries the byte and
// tuser marks the first byte of a new region, which clears the running total, the stop
// flag and any partial instruction. Every accepted byte updates the decoder state in the
// same cycle. When a byte completes an instruction (or hits an unknown opcode or a bad group
// reg field) the result is loaded into the output register and appears on the master stream
// in the cycle after the byte was accepted. Throughput is one byte per cycle unless a result
// stalls, limited by the single pass through the opcode table and the counters. The output
// register decouples the sides: a new byte is taken while a result waits only if that result
// leaves in the same cycle, so tready drops while the receiver stalls with a result pending.
// After reset the decoder is stopped and ignores bytes until one arrives with tuser set;
// min_length resets to 5. Once the total reaches min_length, or a byte gives an error,
// decoding stops again until the next region start.
// The APB port holds min_length at address 0; pready is always high.
`default_nettype none

module x86_instruction_length_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  input  logic        s_axis_tuser,   // [0] begin_req
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] insn_length, [9:5] reloc_offset, [16:10] total_length,
  // [17] reached_minimum, [23:18] zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] status
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xld_pkg::*;

  // Configuration register.
  logic [6:0] min_length_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_LENGTH);
  assign prdata = (paddr[2] == REG_MIN_LENGTH) ? {25'd0, min_length_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= MIN_LENGTH_RESET;
    end else if (cfg_wr) begin
      min_length_q <= pwdata[6:0];
    end
  end

  // Decoder state.
  phase_e          phase_q, phase_d;
  logic [4:0]      bytes_q, bytes_d;
  logic [3:0]      tail_q, tail_d;
  logic [3:0]      opb_q, opb_d;
  logic [PcW-1:0]  pc_q, pc_d;
  op_info_t        held_q, held_d;
  logic [4:0]      reloc_q, reloc_d;
  logic [6:0]      total_q, total_d;
  logic            stopped_q, stopped_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [17:0] out_data_q, out_data_d;
  logic        out_status_q, out_status_d;

  logic       in_acc;
  logic       res_valid;
  logic       res_error;
  logic       res_done;
  op_info_t   byte_info;
  logic [4:0] bytes_base;
  logic [6:0] total_base;
  logic [4:0] bytes_n;
  logic [7:0] sum_w;
  logic [6:0] total_sat;
  logic [6:0] lim;
  logic       hit;
  logic [3:0] disp;
  logic [3:0] tail_set;
  logic       tail_path;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Lookup of the incoming byte as an opcode.
  xld_op_decode u_op_decode (
    .opcode_i (s_axis_tdata),
    .info_o   (byte_info)
  );

  // Completion arithmetic: saturated running total and the minimum check.
  // A region start counts from zero.
  always_comb begin
    bytes_base = s_axis_tuser ? 5'd0 : bytes_q;
    total_base = s_axis_tuser ? 7'd0 : total_q;
    bytes_n    = bytes_base + 5'd1;
    sum_w      = {1'b0, total_base} + {3'b000, bytes_n};
    total_sat  = sum_w[7] ? 7'd127 : sum_w[6:0];
    lim        = (min_length_q == 7'd0) ? 7'd1 : min_length_q;
    hit        = total_sat >= lim;
  end

  // Per-byte step: next state and result.
  always_comb begin
    // Region start clears the partial instruction and total first.
    if (s_axis_tuser) begin
      phase_d   = PH_PREFIX;
      bytes_d   = 5'd0;
      tail_d    = 4'd0;
      opb_d     = 4'd4;
      pc_d      = '0;
      held_d    = '0;
      reloc_d   = 5'd0;
      total_d   = 7'd0;
      stopped_d = 1'b0;
    end else begin
      phase_d   = phase_q;
      bytes_d   = bytes_q;
      tail_d    = tail_q;
      opb_d     = opb_q;
      pc_d      = pc_q;
      held_d    = held_q;
      reloc_d   = reloc_q;
      total_d   = total_q;
      stopped_d = stopped_q;
    end

    res_error = 1'b0;
    res_done  = 1'b0;
    tail_path = 1'b0;
    tail_set  = 4'd0;
    disp      = 4'd0;

    if (!stopped_d) begin
      unique case (phase_d)
        PH_PREFIX, PH_OPCODE: begin
          if (phase_d == PH_PREFIX && pc_d < PcW'(MAX_PREFIXES) &&
              is_prefix(s_axis_tdata)) begin
            pc_d = pc_d + PcW'(1);
            if (s_axis_tdata == OPSIZE_PREFIX) opb_d = 4'd2;
          end else if (phase_d == PH_PREFIX && s_axis_tdata[7:4] == REX_HIGH) begin
            if (s_axis_tdata[3]) opb_d = 4'd8;
            phase_d = PH_OPCODE;
          end else if (!byte_info.found) begin
            res_error = 1'b1;
          end else if (byte_info.flags.modrm) begin
            held_d  = byte_info;
            phase_d = PH_MODRM;
          end else begin
            if (byte_info.flags.rel) reloc_d = bytes_n;
            tail_set  = imm_bytes(byte_info.flags, opb_d);
            tail_path = 1'b1;
          end
        end
        PH_MODRM: begin
          if (held_d.flags.group && !held_d.regs[s_axis_tdata[5:3]]) begin
            res_error = 1'b1;
          end else begin
            if (s_axis_tdata[7:6] == 2'd1) begin
              disp = 4'd1;
            end else if (s_axis_tdata[7:6] == 2'd2) begin
              disp = 4'd4;
            end else if (s_axis_tdata[7:6] == 2'd0 && s_axis_tdata[2:0] == 3'd5) begin
              disp    = 4'd4;
              reloc_d = bytes_n;
            end
            tail_set = disp + imm_bytes(held_d.flags, opb_d);
            if (s_axis_tdata[7:6] != 2'd3 && s_axis_tdata[2:0] == 3'd4) begin
              tail_d  = tail_set;
              phase_d = (s_axis_tdata[7:6] == 2'd0) ? PH_SIB_MOD0 : PH_SIB;
            end else begin
              tail_path = 1'b1;
            end
          end
        end
        PH_SIB_MOD0: begin
          tail_set  = (s_axis_tdata[2:0] == 3'd5) ? tail_d + 4'd4 : tail_d;
          tail_path = 1'b1;
        end
        PH_SIB: begin
          tail_set  = tail_d;
          tail_path = 1'b1;
        end
        PH_TAIL: begin
          if (tail_d != 4'd0) tail_d = tail_d - 4'd1;
          if (tail_d == 4'd0) res_done = 1'b1;
        end
        default: begin
          phase_d = PH_PREFIX;
          pc_d    = '0;
          opb_d   = 4'd4;
          reloc_d = 5'd0;
          tail_d  = 4'd0;
          held_d  = '0;
        end
      endcase

      // Tail count known: finish now, or wait for the trailing bytes.
      if (tail_path) begin
        tail_d = tail_set;
        if (tail_set == 4'd0) res_done = 1'b1;
        else phase_d = PH_TAIL;
      end
    end

    res_valid    = res_done || res_error;
    out_status_d = res_error;
    out_data_d   = '0;
    if (res_done) begin
      out_data_d = {hit, total_sat, reloc_d, bytes_n};
    end

    // Byte count of the instruction in progress.
    if (!stopped_d) begin
      bytes_d = bytes_n;
      if (phase_d == PH_PREFIX && !res_valid && phase_q != PH_PREFIX && !s_axis_tuser) begin
        bytes_d = 5'd0;
      end
    end

    // A finished instruction or an error clears the instruction state.
    if (res_valid) begin
      phase_d = PH_PREFIX;
      bytes_d = 5'd0;
      tail_d  = 4'd0;
      opb_d   = 4'd4;
      pc_d    = '0;
      held_d  = '0;
      reloc_d = 5'd0;
      if (res_error) begin
        total_d   = 7'd0;
        stopped_d = 1'b1;
      end else begin
        total_d   = total_sat;
        stopped_d = hit;
      end
    end

    // The output register keeps its result until the receiver takes it.
    if (in_acc && res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PREFIX;
      bytes_q     <= 5'd0;
      tail_q      <= 4'd0;
      opb_q       <= 4'd4;
      pc_q        <= '0;
      held_q      <= '0;
      reloc_q     <= 5'd0;
      total_q     <= 7'd0;
      stopped_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q   <= phase_d;
        bytes_q   <= bytes_d;
        tail_q    <= tail_d;
        opb_q     <= opb_d;
        pc_q      <= pc_d;
        held_q    <= held_d;
        reloc_q   <= reloc_d;
        total_q   <= total_d;
        stopped_q <= stopped_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};
  assign m_axis_tuser  = out_status_q;

  // An error result carries nothing but the status flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
    else $error("error result with nonzero fields");

  // A decoded instruction has a length and the total covers it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[16:10] >= {2'b00, m_axis_tdata[4:0]})
    else $error("decoded result with bad length or total");

  // Reaching the minimum or an error stops the decoder.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_valid && (res_error || hit) |=> stopped_q)
    else $error("decoder did not stop after final result");

  // A stalled result blocks new bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("byte accepted while a result is stalled");

endmodule

`default_nettype wire
